[rtl/core/asp_pkg.sv]
package asp_pkg;

    localparam int CodeW   = 6;
    localparam int HeldW   = 3 * CodeW;
    localparam int WordW   = 4 * CodeW;
    localparam int FillW   = 2;
    localparam int QDepth  = 2;
    localparam int QPtrW   = 1;
    localparam int QCntW   = 2;

    localparam logic [CodeW-1:0] CODE_OTHER      = 6'd62;
    localparam logic [CodeW-1:0] CODE_LOWER_BASE = 6'd10;
    localparam logic [CodeW-1:0] CODE_UPPER_BASE = 6'd36;
    localparam logic [7:0]       DIGIT_ZERO      = 8'd48;

    // One packed group plus, on the stream's end, its trailer digit.
    typedef struct packed {
        logic [WordW-1:0] word;
        logic             trailer;
        logic [FillW-1:0] count;
    } job_t;

endpackage

[rtl/core/asp_front.sv]
module asp_front
    import asp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [HeldW-1:0] held_reg;
    logic [HeldW-1:0] held_next;
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;
    logic [CodeW-1:0] code;
    logic [HeldW-1:0] grown;
    logic [FillW-1:0] grown_fill;
    logic             accept;

    always_comb
    begin
        if (in_char >= 8'h30 && in_char <= 8'h39)
            code = CodeW'(in_char - 8'h30);
        else if (in_char >= 8'h61 && in_char <= 8'h7a)
            code = CODE_LOWER_BASE + CodeW'(in_char - 8'h61);
        else if (in_char >= 8'h41 && in_char <= 8'h5a)
            code = CODE_UPPER_BASE + CodeW'(in_char - 8'h41);
        else
            code = CODE_OTHER;
    end

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign grown      = {held_reg[HeldW-CodeW-1:0], code};
    assign grown_fill = fill_reg + 2'd1;

    always_comb
    begin
        push_job          = '0;
        push              = 1'b0;
        held_next         = held_reg;
        fill_next         = fill_reg;
        push_job.trailer  = in_last;
        if (fill_reg == 2'd3)
        begin
            push          = accept;
            push_job.word = {held_reg, code};
            push_job.count = 2'd0;
            held_next     = '0;
            fill_next     = '0;
        end
        else if (in_last)
        begin
            // flush: pad unused slots with the "other" code
            push           = accept;
            push_job.count = grown_fill;
            case (grown_fill)
                2'd1:    push_job.word = {grown[CodeW-1:0], CODE_OTHER, CODE_OTHER,
                                          CODE_OTHER};
                2'd2:    push_job.word = {grown[2*CodeW-1:0], CODE_OTHER, CODE_OTHER};
                default: push_job.word = {grown, CODE_OTHER};
            endcase
            held_next = '0;
            fill_next = '0;
        end
        else
        begin
            held_next = grown;
            fill_next = grown_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/core/asp_queue.sv]
module asp_queue
    import asp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic avail,
    input  logic pop,
    output job_t pop_job
);

    job_t             slot_reg [QDepth];
    logic [QPtrW-1:0] wr_reg;
    logic [QPtrW-1:0] rd_reg;
    logic [QCntW-1:0] cnt_reg;
    logic [QCntW-1:0] cnt_next;

    assign full    = (cnt_reg == QCntW'(QDepth));
    assign avail   = (cnt_reg != '0);
    assign pop_job = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

[rtl/core/asp_back.sv]
module asp_back
    import asp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_avail,
    output logic       q_pop,
    input  job_t       q_job,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    job_t       job_reg;
    logic       busy_reg;
    logic [1:0] step_reg;
    logic       beat;
    logic       done;

    assign out_valid = busy_reg;
    assign beat      = busy_reg && !out_stall;
    assign done      = (step_reg == 2'd3) || (step_reg == 2'd2 && !job_reg.trailer);
    assign q_pop     = q_avail && (!busy_reg || (beat && done));

    always_comb
    begin
        out_last = 1'b0;
        case (step_reg)
            2'd0:    out_byte = job_reg.word[23:16];
            2'd1:    out_byte = job_reg.word[15:8];
            2'd2:    out_byte = job_reg.word[7:0];
            default:
            begin
                out_byte = DIGIT_ZERO + 8'(job_reg.count);
                out_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (beat)
        begin
            if (done)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
    end

endmodule

[rtl/core/ascii_six_bit_packer.sv]
// Channel | Handshake           | Beat payload
// input   | in_valid / in_stall | in_char[7:0], in_last
// output  | out_valid/out_stall | out_byte[7:0], out_last
//
// One character is taken per unstalled cycle; the front codes it and, when
// a group is complete or the stream ends, hands a job to a two-entry queue.
// The back drains one byte per unstalled cycle; 3 beats/group, 4 with trailer.
// Input stalls only while the queue holds two jobs (e.g. short last-marked
// streams); sustained rate is one character per cycle otherwise.
// Reset clears the partial group; a new stream may follow the trailer at once.
module ascii_six_bit_packer
    import asp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic push;
    job_t push_job;
    logic q_full;
    logic q_avail;
    logic q_pop;
    job_t q_job;

    asp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_char  (in_char),
        .in_last  (in_last),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    asp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .avail    (q_avail),
        .pop      (q_pop),
        .pop_job  (q_job)
    );

    asp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (q_avail),
        .q_pop     (q_pop),
        .q_job     (q_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

[tb/sv/ascii_six_bit_packer_tb.sv]
module ascii_six_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'd0;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    ascii_six_bit_packer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // predictor state
    logic [HeldW-1:0] held_codes = '0;
    logic [FillW-1:0] group_fill = '0;

    beat_t pending_chars[$];
    beat_t expected_bytes[$];

    int unsigned cyc = 0;
    int          n_in = 0;
    int          n_out = 0;
    int          n_streams = 0;
    int          n_in_stalls = 0;
    int          n_holds = 0;
    int          fails = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          in_taken = 1'b0;
    bit          hold_off = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CodeW-1:0] six_bit_code(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return CodeW'(ch - "0");
        if (ch >= "a" && ch <= "z")
            return CodeW'(CODE_LOWER_BASE + (ch - "a"));
        if (ch >= "A" && ch <= "Z")
            return CodeW'(CODE_UPPER_BASE + (ch - "A"));
        return CODE_OTHER;
    endfunction

    task automatic push_word(input logic [WordW-1:0] word);
        expected_bytes.push_back('{word[23:16], 1'b0});
        expected_bytes.push_back('{word[15:8], 1'b0});
        expected_bytes.push_back('{word[7:0], 1'b0});
    endtask

    task automatic pack_char(input logic [7:0] ch, input logic last);
        logic [CodeW-1:0] code;
        logic [WordW-1:0] word;
        int               n;
        code = six_bit_code(ch);
        if (group_fill == 2'd3) begin
            push_word({held_codes, code});
            held_codes = '0;
            group_fill = '0;
        end
        else begin
            held_codes = {held_codes[HeldW-CodeW-1:0], code};
            group_fill = group_fill + 1'b1;
        end
        if (last) begin
            n = group_fill;
            if (n != 0) begin
                word = WordW'(held_codes);
                // pad unused slots with the catch-all code
                for (int s = n; s < 4; s++)
                    word = {word[WordW-CodeW-1:0], CODE_OTHER};
                push_word(word);
            end
            expected_bytes.push_back('{DIGIT_ZERO + 8'(n), 1'b1});
            held_codes = '0;
            group_fill = '0;
            n_streams++;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (cyc[8:7] == 2'd0)
            return 0;   // quiet stretch, no idling
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(61);
        if ($urandom_range(9) < 3)
            return 8'($urandom_range(255));
        if (r < 10)
            return 8'("0" + r);
        if (r < 36)
            return 8'("a" + r - 10);
        return 8'("A" + r - 36);
    endfunction

    task automatic add_item(input logic [7:0] ch, input logic last);
        pending_chars.push_back('{ch, last});
    endtask

    task automatic add_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], close && (i == s.len() - 1));
    endtask

    // input driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap = in_gap - 1;
                end
                else if (pending_chars.size() > 0) begin
                    beat_t nxt;
                    nxt = pending_chars.pop_front();
                    in_valid <= 1'b1;
                    in_char  <= nxt.data;
                    in_last  <= nxt.last;
                    in_gap = pick_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_off) begin
                out_stall <= 1'b1;
            end
            else if (out_gap > 0) begin
                out_stall <= 1'b1;
                out_gap = out_gap - 1;
            end
            else begin
                out_stall <= 1'b0;
                out_gap = pick_gap();
            end
        end
    end

    // monitor: predicts on input beats, checks output beats
    always @(posedge clk) begin
        beat_t want;
        cyc++;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if (in_valid && in_stall)
                n_in_stalls++;
            if (in_valid && !in_stall) begin
                pack_char(in_char, in_last);
                n_in++;
            end
            if (out_valid && !out_stall) begin
                if (expected_bytes.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected beat byte=%02h last=%0b",
                                 $realtime, out_byte, out_last);
                end
                else begin
                    want = expected_bytes.pop_front();
                    n_out++;
                    if (out_byte !== want.data || out_last !== want.last) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: beat %0d expected byte=%02h last=%0b,",
                                      " got byte=%02h last=%0b"},
                                     $realtime, n_out, want.data, want.last,
                                     out_byte, out_last);
                    end
                end
            end
        end
    end

    // long receiver hold-offs so the block backs up and stalls its input
    initial begin
        int marks[2];
        marks = '{80, 320};
        foreach (marks[k]) begin
            wait (n_in >= marks[k]);
            @(posedge clk);
            hold_off = 1'b1;
            repeat (150) @(posedge clk);
            hold_off = 1'b0;
            n_holds++;
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int total;
        int len;

        // full groups, class boundaries, then a 3-code partial flush
        add_text("09azAZ@[/:", 1'b0);
        add_item(8'h60, 1'b0);
        add_item("{", 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h80, 1'b1);
        // single-char stream, 2-code flush, full group on the last beat
        add_text("Q", 1'b1);
        add_text("x7", 1'b1);
        add_text("kL5", 1'b0);
        add_item(8'h7F, 1'b1);

        total = pending_chars.size();
        while (total < 480) begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(64, 20);
            else
                len = $urandom_range(16, 1);
            for (int i = 0; i < len; i++)
                add_item(random_char(), i == len - 1);
            total += len;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d characters in %0d streams, %0d output beats checked",
                 n_in, n_streams, n_out);
        $display("%0d long output hold-offs, %0d cycles of input backpressure",
                 n_holds, n_in_stalls);
        if (fails == 0 && expected_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
